@@ design/shma_pkg.sv @@
// ----------------------------------------------------------------------------
// Sample history package
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shma_pkg;

    // Register and field widths fixed by the register map
    localparam int CFG_BITS       = 7;
    localparam int IDX_BITS       = 7;
    localparam int CFG_INDEX_BITS = 2;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HISTORY_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AVG_WINDOW     = 2'd1;

    // Register reset values
    localparam logic [CFG_BITS-1:0] HIST_LEN_RESET = 7'd64;
    localparam logic [CFG_BITS-1:0] AVG_WIN_RESET  = 7'd2;

    // A zero window acts as this window
    localparam logic [CFG_BITS-1:0] WIN_DEFAULT = 7'd2;

    // Operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic capture;
        logic add_commit;
        logic rd_issue;
        logic div_load;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic op_read;
        logic empty;
        logic last_issue;
        logic div_done;
        logic out_free;
    } ctrl_status_t;

endpackage

@@ design/shma_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/shma_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sample history controller
// Sequences add, history walk, division and result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shma_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output shma_pkg::ctrl_cmd_t    cmd,
    input  shma_pkg::ctrl_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ADD,
        S_RD_ISSUE,
        S_RD_DRAIN,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (!status.op_read)
                begin
                    state_next = S_ADD;
                end
                else if (status.empty)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_RD_ISSUE;
                end
            end
            S_ADD:
            begin
                cmd.add_commit = 1'b1;
                state_next     = S_FINISH;
            end
            S_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                if (status.last_issue)
                begin
                    state_next = S_RD_DRAIN;
                end
            end
            S_RD_DRAIN:
            begin
                // last read data lands in the accumulator here
                state_next = S_DIV_LOAD;
            end
            S_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                if (status.div_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/shma_dp.sv @@
// ----------------------------------------------------------------------------
// Sample history datapath
// Pointers, bounds, history RAM, window accumulator, divider, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shma_dp #(
    parameter int DEPTH       = 64,
    parameter int SAMPLE_BITS = 32,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [shma_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [shma_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic                                  op,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic [shma_pkg::IDX_BITS-1:0]         read_index,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [SAMPLE_BITS-1:0]         value,
    output logic signed [SAMPLE_BITS-1:0]         moving_avg,
    output logic signed [SAMPLE_BITS-1:0]         upper_bound,
    output logic signed [SAMPLE_BITS-1:0]         lower_bound,
    output logic [CW-1:0]                         count,
    output logic                                  empty_res,
    input  shma_pkg::ctrl_cmd_t                   cmd,
    output shma_pkg::ctrl_status_t                status
);

    localparam int SB   = SAMPLE_BITS;
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WB   = shma_pkg::CFG_BITS;
    localparam int IW   = shma_pkg::IDX_BITS;
    localparam int PW   = (IW > CW) ? IW : CW;
    localparam int XW   = ((PW > WB) ? PW : WB) + 1;
    localparam int SUMW = SB + WB;
    localparam int DCW  = $clog2(SUMW + 1);
    localparam logic [AW:0]     DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0]   PTR_LAST = AW'(DEPTH - 1);
    localparam logic [XW-1:0]   DEPTH_X = XW'(DEPTH);

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_A)
        begin
            s = s - DEPTH_A;
        end
        return s[AW-1:0];
    endfunction

    // Configuration
    logic [WB-1:0] hist_len_reg;
    logic [WB-1:0] avg_win_reg;

    // History state
    logic [AW-1:0]        oldest_ptr_reg;
    logic [CW-1:0]        held_count_reg;
    logic signed [SB-1:0] max_reg;
    logic signed [SB-1:0] min_reg;

    // Item registers
    logic                 empty_reg;
    logic                 op_read_reg;
    logic signed [SB-1:0] sample_reg;
    logic [CW-1:0]        pos_reg;
    logic [WB-1:0]        win_reg;
    logic                 need_avg_reg;
    logic [CW-1:0]        walk_pos_reg;
    logic [WB-1:0]        issue_left_reg;
    logic                 first_reg;
    logic                 pend_reg;
    logic                 pend_first_reg;
    logic signed [SB-1:0] val_reg;
    logic signed [SUMW-1:0] sum_reg;

    // Divider
    logic [SUMW-1:0] dq_reg;
    logic [WB-1:0]   rem_reg;
    logic [DCW-1:0]  div_cnt_reg;
    logic            neg_reg;

    // Output register
    logic                 out_valid_reg;
    logic signed [SB-1:0] value_reg;
    logic signed [SB-1:0] avg_reg;
    logic signed [SB-1:0] upper_reg;
    logic signed [SB-1:0] lower_reg;
    logic [CW-1:0]        count_reg;
    logic                 empty_res_reg;

    // RAM
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [SB-1:0] rdata;

    // Add path
    logic [XW-1:0] held_x;
    logic [XW-1:0] hist_x;
    logic [XW-1:0] eff_len_x;
    logic          evict;
    logic [AW-1:0] ptr_inc;
    logic [AW-1:0] new_oldest;
    logic [CW-1:0] new_base;
    logic [CW-1:0] new_held;

    // Read setup
    logic [XW-1:0] ridx_x;
    logic [CW-1:0] pos_c;
    logic [WB-1:0] win_eff;
    logic          need_avg_c;
    logic [CW-1:0] p0;

    // Divider step
    logic [WB:0]     rem_sh;
    logic            q_bit;
    logic [WB:0]     rem_sub;
    logic [SUMW-1:0] sum_mag;
    logic [SUMW-1:0] avg_full;

    always_comb
    begin
        held_x = XW'(held_count_reg);
        hist_x = XW'(hist_len_reg);
        priority if (hist_len_reg == '0)
        begin
            eff_len_x = XW'(1);
        end
        else if (hist_x > DEPTH_X)
        begin
            eff_len_x = DEPTH_X;
        end
        else
        begin
            eff_len_x = hist_x;
        end
        evict      = (held_x >= eff_len_x) && (held_count_reg != '0);
        ptr_inc    = (oldest_ptr_reg == PTR_LAST) ? '0 : oldest_ptr_reg + AW'(1);
        new_oldest = evict ? ptr_inc : oldest_ptr_reg;
        new_base   = evict ? held_count_reg - CW'(1) : held_count_reg;
        new_held   = new_base + CW'(1);
        waddr      = wrap_add(new_oldest, new_base[AW-1:0]);
    end

    always_comb
    begin
        ridx_x     = XW'(read_index);
        pos_c      = (ridx_x > held_x) ? held_count_reg : CW'(ridx_x);
        win_eff    = (avg_win_reg == '0) ? shma_pkg::WIN_DEFAULT : avg_win_reg;
        need_avg_c = (XW'(pos_c) + XW'(1)) >= XW'(win_eff);
        p0         = (pos_c == held_count_reg) ? held_count_reg - CW'(1) : pos_c;
    end

    assign raddr = wrap_add(oldest_ptr_reg, walk_pos_reg[AW-1:0]);

    always_comb
    begin
        rem_sh   = {rem_reg, dq_reg[SUMW-1]};
        q_bit    = rem_sh >= {1'b0, win_reg};
        rem_sub  = rem_sh - {1'b0, win_reg};
        sum_mag  = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : SUMW'(sum_reg);
        avg_full = neg_reg ? (~dq_reg + SUMW'(1)) : dq_reg;
    end

    shma_ram #(
        .WIDTH (SB),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (cmd.add_commit),
        .waddr (waddr),
        .wdata (sample_reg),
        .re    (cmd.rd_issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_len_reg   <= shma_pkg::HIST_LEN_RESET;
            avg_win_reg    <= shma_pkg::AVG_WIN_RESET;
            oldest_ptr_reg <= '0;
            held_count_reg <= '0;
            max_reg        <= '0;
            min_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_first_reg <= 1'b0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == shma_pkg::CFG_HISTORY_LENGTH)
                begin
                    hist_len_reg <= cfg_data;
                end
                else if (cfg_index == shma_pkg::CFG_AVG_WINDOW)
                begin
                    avg_win_reg <= cfg_data;
                end
            end

            if (cmd.add_commit)
            begin
                oldest_ptr_reg <= new_oldest;
                held_count_reg <= new_held;
                // first sample in the history sets both bounds
                if (new_held == CW'(1))
                begin
                    max_reg <= sample_reg;
                    min_reg <= sample_reg;
                end
                else
                begin
                    if (max_reg < sample_reg)
                    begin
                        max_reg <= sample_reg;
                    end
                    if (sample_reg < min_reg)
                    begin
                        min_reg <= sample_reg;
                    end
                end
            end

            pend_reg       <= cmd.rd_issue;
            pend_first_reg <= cmd.rd_issue && first_reg;

            if (cmd.div_load)
            begin
                div_cnt_reg <= DCW'(SUMW);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - DCW'(1);
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item payload, accumulator and divider
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_read_reg    <= (op == shma_pkg::OP_READ);
            empty_reg      <= (op == shma_pkg::OP_READ) && (held_count_reg == '0);
            sample_reg     <= sample;
            pos_reg        <= pos_c;
            win_reg        <= win_eff;
            need_avg_reg   <= need_avg_c;
            walk_pos_reg   <= p0;
            issue_left_reg <= need_avg_c ? win_eff - WB'(1) : '0;
            first_reg      <= 1'b1;
            val_reg        <= (op == shma_pkg::OP_ADD) ? sample : '0;
            sum_reg        <= '0;
            dq_reg         <= '0;
            neg_reg        <= 1'b0;
        end

        if (cmd.rd_issue)
        begin
            // after the first read, walk down from position - 1
            walk_pos_reg   <= (first_reg ? pos_reg : walk_pos_reg) - CW'(1);
            first_reg      <= 1'b0;
            issue_left_reg <= issue_left_reg - WB'(1);
        end

        if (pend_reg)
        begin
            sum_reg <= sum_reg + SUMW'(signed'(rdata));
            if (pend_first_reg)
            begin
                val_reg <= rdata;
            end
        end

        if (cmd.div_load)
        begin
            neg_reg <= sum_reg[SUMW-1] && need_avg_reg;
            dq_reg  <= need_avg_reg ? sum_mag : '0;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? rem_sub[WB-1:0] : rem_sh[WB-1:0];
            dq_reg  <= {dq_reg[SUMW-2:0], q_bit};
        end

        if (cmd.out_load)
        begin
            value_reg     <= val_reg;
            avg_reg       <= avg_full[SB-1:0];
            upper_reg     <= max_reg;
            lower_reg     <= min_reg;
            count_reg     <= held_count_reg;
            empty_res_reg <= empty_reg;
        end
    end

    always_comb
    begin
        status.op_read    = op_read_reg;
        status.empty      = empty_reg;
        status.last_issue = (issue_left_reg == '0);
        status.div_done   = (div_cnt_reg == '0);
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign moving_avg  = avg_reg;
    assign upper_bound = upper_reg;
    assign lower_bound = lower_reg;
    assign count       = count_reg;
    assign empty_res   = empty_res_reg;

endmodule

@@ design/sample_history_moving_average_top.sv @@
// ----------------------------------------------------------------------------
// Sample history with moving average
// Add and empty read skip the history walk. A read makes W history RAM
// reads at one per cycle (W is the window, or 1 when the position is too
// early for it), then runs a one-bit-per-cycle divider. One item at a time.
// Reset clears the history, pointers and bounds and restores register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sample_history_moving_average_top #(
    parameter int DEPTH       = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [shma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [shma_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic [shma_pkg::IDX_BITS-1:0]       read_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       value,
    output logic signed [SAMPLE_BITS-1:0]       moving_avg,
    output logic signed [SAMPLE_BITS-1:0]       upper_bound,
    output logic signed [SAMPLE_BITS-1:0]       lower_bound,
    output logic [$clog2(DEPTH + 1)-1:0]        count,
    output logic                                empty_res
);

    shma_pkg::ctrl_cmd_t    cmd;
    shma_pkg::ctrl_status_t status;

    // register writes take effect in the next cycle
    assign cfg_ready = 1'b1;

    shma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    shma_dp #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .sample      (sample),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .moving_avg  (moving_avg),
        .upper_bound (upper_bound),
        .lower_bound (lower_bound),
        .count       (count),
        .empty_res   (empty_res),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
